### design/ppmfd_pkg.sv
package ppmfd_pkg;

   // Field widths
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned WIDTH_W  = 16;
   localparam int unsigned SUM_W    = WIDTH_W + 1;
   localparam int unsigned INDEX_W  = 3;
   localparam int unsigned CSR_IDX_W  = 8;
   localparam int unsigned CSR_DATA_W = 32;

   // Result carries a fixed set of six channel fields
   localparam int unsigned NUM_FIELDS    = 6;
   localparam int unsigned NUM_SLOTS_DEF = 6;

   localparam logic [INDEX_W-1:0] EMIT_INDEX = 3'd5;
   localparam logic [INDEX_W-1:0] INDEX_MAX  = 3'd7;

   // Register reset values
   localparam logic [WIDTH_W-1:0] PULSE_MAX_RST  = 16'd510;
   localparam logic [WIDTH_W-1:0] SYNC_MIN_RST   = 16'd1910;
   localparam logic [WIDTH_W-1:0] VALUE_LOW_RST  = 16'd810;
   localparam logic [WIDTH_W-1:0] VALUE_HIGH_RST = 16'd2210;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PULSE_MAX  = 8'd0,
      REG_SYNC_MIN   = 8'd1,
      REG_VALUE_LOW  = 8'd2,
      REG_VALUE_HIGH = 8'd3
   } reg_index_type;

   typedef struct packed {
      logic [WIDTH_W-1:0] pulse_max;
      logic [WIDTH_W-1:0] sync_min;
      logic [WIDTH_W-1:0] value_low;
      logic [WIDTH_W-1:0] value_high;
   } cfg_type;

   typedef logic [NUM_FIELDS-1:0][WIDTH_W-1:0] frame_type;

   typedef struct packed {
      logic      valid;
      frame_type frame;
   } step_type;

endpackage

### design/ppmfd_if.sv
interface ppmfd_req_if import ppmfd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] edge_time;

   modport source (output valid, output edge_time, input ready);
   modport sink   (input valid, input edge_time, output ready);
endinterface

interface ppmfd_rsp_if import ppmfd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [WIDTH_W-1:0] ch1_width;
   logic [WIDTH_W-1:0] ch2_width;
   logic [WIDTH_W-1:0] ch3_width;
   logic [WIDTH_W-1:0] ch4_width;
   logic [WIDTH_W-1:0] ch5_width;
   logic [WIDTH_W-1:0] ch6_width;

   modport source (output valid, output ch1_width, output ch2_width, output ch3_width,
                   output ch4_width, output ch5_width, output ch6_width, input ready);
   modport sink   (input valid, input ch1_width, input ch2_width, input ch3_width,
                   input ch4_width, input ch5_width, input ch6_width, output ready);
endinterface

interface ppmfd_csr_if import ppmfd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### design/ppmfd_csr.sv
module ppmfd_csr import ppmfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ppmfd_csr_if.sink   csr_chan,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_chan.ready = 1'b1;
   assign wr_en          = csr_chan.valid;
   assign cfg            = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_chan.index)
            REG_PULSE_MAX:  cfg_in.pulse_max  = csr_chan.data[WIDTH_W-1:0];
            REG_SYNC_MIN:   cfg_in.sync_min   = csr_chan.data[WIDTH_W-1:0];
            REG_VALUE_LOW:  cfg_in.value_low  = csr_chan.data[WIDTH_W-1:0];
            REG_VALUE_HIGH: cfg_in.value_high = csr_chan.data[WIDTH_W-1:0];
            default:        cfg_in = cfg_ff; // unknown index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_max  <= PULSE_MAX_RST;
         cfg_ff.sync_min   <= SYNC_MIN_RST;
         cfg_ff.value_low  <= VALUE_LOW_RST;
         cfg_ff.value_high <= VALUE_HIGH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### design/ppmfd_core.sv
module ppmfd_core import ppmfd_pkg::*; #(
   parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   ppmfd_req_if.sink   req_chan,
   input  logic        advance,
   output step_type    step
);

   // Input register
   logic              in_valid_ff, in_valid_in;
   logic [TIME_W-1:0] in_time_ff;
   logic              take;
   logic              fire;

   // Decoder state
   logic [TIME_W-1:0]  last_edge_ff, last_edge_in;
   logic [WIDTH_W-1:0] pulse_width_ff, pulse_width_in;
   logic [INDEX_W-1:0] slot_index_ff, slot_index_in;
   logic [WIDTH_W-1:0] slot_ff [NUM_SLOTS];
   logic [WIDTH_W-1:0] slot_in [NUM_SLOTS];

   logic [TIME_W-1:0] interval;
   logic [SUM_W-1:0]  sum;
   logic              is_pulse;
   logic              is_sync;
   logic              in_range;
   logic              slot_exists;

   assign fire          = in_valid_ff & advance;
   assign req_chan.ready = ~in_valid_ff | advance;
   assign take          = req_chan.valid & req_chan.ready;

   always_comb begin
      priority if (take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_time_ff <= req_chan.edge_time;
      end
   end

   // Classify the interval: pulse test first, then sync
   assign interval    = in_time_ff - last_edge_ff;
   assign is_pulse    = interval < {{(TIME_W-WIDTH_W){1'b0}}, cfg.pulse_max};
   assign is_sync     = interval > {{(TIME_W-WIDTH_W){1'b0}}, cfg.sync_min};
   assign sum         = {1'b0, interval[WIDTH_W-1:0]} + {1'b0, pulse_width_ff};
   assign slot_exists = {{(32-INDEX_W){1'b0}}, slot_index_ff} < 32'(NUM_SLOTS);
   assign in_range    = (sum > {1'b0, cfg.value_low}) && (sum < {1'b0, cfg.value_high})
                        && slot_exists;

   always_comb begin
      last_edge_in   = in_time_ff;
      pulse_width_in = pulse_width_ff;
      slot_index_in  = slot_index_ff;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_in[i] = slot_ff[i];
      end
      priority if (is_pulse) begin
         pulse_width_in = interval[WIDTH_W-1:0];
      end else if (is_sync) begin
         slot_index_in = '0;
      end else begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (in_range && slot_index_ff == INDEX_W'(i)) begin
               slot_in[i] = sum[WIDTH_W-1:0];
            end
         end
         if (slot_index_ff != INDEX_MAX) begin
            slot_index_in = slot_index_ff + INDEX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_edge_ff   <= '0;
         pulse_width_ff <= '0;
         slot_index_ff  <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_ff[i] <= '0;
         end
      end else if (fire) begin
         last_edge_ff   <= last_edge_in;
         pulse_width_ff <= pulse_width_in;
         slot_index_ff  <= slot_index_in;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_ff[i] <= slot_in[i];
         end
      end
   end

   // Frame goes out whenever the index lands on the emit slot
   assign step.valid = fire && (slot_index_in == EMIT_INDEX);

   for (genvar j = 0; j < NUM_FIELDS; j++) begin : g_field
      if (j < NUM_SLOTS) begin : g_slot
         assign step.frame[j] = slot_in[j];
      end else begin : g_zero
         assign step.frame[j] = '0;
      end
   end

endmodule

### design/ppm_frame_decoder.sv
// PPM frame decoder.
// req_chan carries one edge timestamp (edge_time, microseconds, wrapping)
// per transfer. Each edge updates the pulse, sync and channel-slot state;
// whenever an edge leaves the channel index at 5, one transfer on rsp_chan
// carries all six slot widths (ch1_width .. ch6_width, slots beyond
// NUM_SLOTS read as zero). Edges that give no frame produce nothing.
// csr_chan writes the four threshold registers (index 0..3, low 16 data
// bits kept, other indexes ignored); it is always ready. The user must write
// it only while the decoder is idle; the block itself does not enforce this.
// An edge is registered in the input register, processed from there and its
// frame registered in the output register, from which rsp_chan offers it.
// Throughput: one edge per cycle while rsp_chan does not stall; an edge is
// taken while a frame waits, with one edge held in the input register.
// Reset (synchronous): thresholds return to 510/1910/810/2210, timestamp
// base, pulse width, index and slots clear to zero, both registers empty.
// rsp_chan stall: the frame holds and the held edge waits; req_chan.ready
// drops once the input register is full and the output is stalled.
module ppm_frame_decoder import ppmfd_pkg::*; #(
   parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   ppmfd_req_if.sink   req_chan,
   ppmfd_rsp_if.source rsp_chan,
   ppmfd_csr_if.sink   csr_chan
);

   cfg_type   cfg;
   step_type  step;
   logic      advance;
   logic      rsp_valid_ff, rsp_valid_in;
   frame_type rsp_frame_ff;

   ppmfd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   ppmfd_core #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .advance  (advance),
      .step     (step)
   );

   // Output register: free when empty or being drained this cycle
   assign advance = ~rsp_valid_ff | rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = step.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step.valid) begin
         rsp_frame_ff <= step.frame;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.ch1_width = rsp_frame_ff[0];
   assign rsp_chan.ch2_width = rsp_frame_ff[1];
   assign rsp_chan.ch3_width = rsp_frame_ff[2];
   assign rsp_chan.ch4_width = rsp_frame_ff[3];
   assign rsp_chan.ch5_width = rsp_frame_ff[4];
   assign rsp_chan.ch6_width = rsp_frame_ff[5];

endmodule
